// File: hdl/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants for the H-bridge serial command decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

  // Parser phase within one command frame.
  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_COMMAND = 2'd1,
    PH_ARG     = 2'd2,
    PH_SPEED   = 2'd3
  } phase_t;

  // Motor selection decoded from the motor byte.
  typedef enum logic [1:0] {
    SEL_A    = 2'd0,
    SEL_B    = 2'd1,
    SEL_BOTH = 2'd2
  } sel_t;

  // Command codes.
  localparam logic [1:0] CMD_SPEED   = 2'd0;
  localparam logic [1:0] CMD_BRAKE   = 2'd1;
  localparam logic [1:0] CMD_COAST   = 2'd2;
  localparam logic [1:0] CMD_STANDBY = 2'd3;

  // Motor byte values with a meaning of their own.
  localparam logic [7:0] MOTOR_BYTE_A    = 8'd0;
  localparam logic [7:0] MOTOR_BYTE_BOTH = 8'd2;

  // Duty scaling.
  localparam logic [7:0] PWM_FLOOR_RESET = 8'd50;
  localparam logic [7:0] DUTY_FULL       = 8'd255;
  localparam logic [7:0] SPEED_MAX_MAG   = 8'd100;

  // Division by 100 is done as a multiply by ceil(2^22 / 100) and a shift.
  // The result is exact for every product below 43690, and the largest
  // product here is 100 * 255.
  localparam int             RecipShift = 22;
  localparam logic [15:0]    RECIP_100  = 16'd41944;
  localparam int             ScaleW     = 24;
  localparam logic [ScaleW-1:0] SCALE_RESET =
    ScaleW'((32'd255 - 32'd50) * 32'd41944);

  // Pins of one bridge.
  typedef struct packed {
    logic       in1;
    logic       in2;
    logic [7:0] duty;
  } bridge_t;

  // All registered driver pins.
  typedef struct packed {
    bridge_t a;
    bridge_t b;
    logic    stby;
  } pins_t;

  // Result of one received byte.
  typedef struct packed {
    pins_t pins;
    logic  done;
    logic  bad;
  } result_t;

endpackage

// File: hdl/hsd_scale.sv
// ----------------------------------------------------------------------------
// hsd_scale
// Holds the PWM floor register and maps a signed speed byte to a duty value.
// ----------------------------------------------------------------------------
module hsd_scale (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic [7:0] speed_byte,
  output logic [7:0] speed_duty
);
  import hsd_pkg::*;

  logic [7:0]        pwm_floor;
  logic [ScaleW-1:0] scale;
  logic [7:0]        span;
  logic [7:0]        mag;
  logic              over;
  logic [30:0]       prod;
  logic [7:0]        quot;

  // The scale factor (255 - floor) * reciprocal is formed when the floor is
  // written, so the per-byte path holds a single multiply.
  assign span = DUTY_FULL - cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_floor <= PWM_FLOOR_RESET;
      scale     <= SCALE_RESET;
    end else if (cfg_we) begin
      pwm_floor <= cfg_data;
      scale     <= {16'd0, span} * {8'd0, RECIP_100};
    end
  end

  // Magnitude of the two's complement speed; -128 gives 128.
  assign mag  = speed_byte[7] ? 8'(~speed_byte + 8'd1) : speed_byte;
  assign over = (mag > SPEED_MAX_MAG);

  // Linear map from 0..100 onto floor..255, saturating above 100.
  assign prod = 31'(mag[6:0]) * 31'(scale);
  assign quot = prod[RecipShift+7:RecipShift];

  assign speed_duty = over ? DUTY_FULL : 8'(pwm_floor + quot);

endmodule

// File: hdl/hsd_decoder.sv
// ----------------------------------------------------------------------------
// hsd_decoder
// Frame parser and registered bridge pins; steps once per received byte.
// ----------------------------------------------------------------------------
module hsd_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       speed_duty,
  output hsd_pkg::result_t result
);
  import hsd_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] pending_cmd, pending_cmd_next;
  sel_t       pending_motor, pending_motor_next;
  pins_t      pins, pins_next;
  logic       done;
  logic       bad;
  sel_t       byte_sel;

  // Bridge levels that one command leaves on one motor.
  function automatic bridge_t drive(bridge_t cur, logic [1:0] cmd, logic [7:0] arg,
                                    logic [7:0] duty);
    bridge_t r;
    r = cur;
    if (cmd == CMD_SPEED) begin
      if (arg == 8'd0) begin
        r = '{in1: 1'b0, in2: 1'b0, duty: DUTY_FULL};
      end else if (arg[7]) begin
        r = '{in1: 1'b0, in2: 1'b1, duty: duty};
      end else begin
        r = '{in1: 1'b1, in2: 1'b0, duty: duty};
      end
    end else if (cmd == CMD_BRAKE) begin
      r.in1 = 1'b1;
      r.in2 = 1'b1;
    end else begin
      r = '{in1: 1'b0, in2: 1'b0, duty: DUTY_FULL};
    end
    return r;
  endfunction

  // Motor byte decode: zero is A, two is both, anything else is B.
  always_comb begin
    if (rx_byte == MOTOR_BYTE_A) begin
      byte_sel = SEL_A;
    end else if (rx_byte == MOTOR_BYTE_BOTH) begin
      byte_sel = SEL_BOTH;
    end else begin
      byte_sel = SEL_B;
    end
  end

  // Next state of the parser and the pins for the byte at hand.
  always_comb begin
    phase_next         = phase;
    pending_cmd_next   = pending_cmd;
    pending_motor_next = pending_motor;
    pins_next          = pins;
    done               = 1'b0;
    bad                = 1'b0;
    unique case (phase)
      PH_LENGTH: begin
        phase_next = PH_COMMAND;
      end
      PH_COMMAND: begin
        if (rx_byte > 8'(CMD_STANDBY)) begin
          done       = 1'b1;
          bad        = 1'b1;
          phase_next = PH_LENGTH;
        end else begin
          pending_cmd_next = rx_byte[1:0];
          phase_next       = PH_ARG;
        end
      end
      PH_ARG: begin
        if (pending_cmd == CMD_STANDBY) begin
          pins_next.stby = (rx_byte == 8'd0);
          done           = 1'b1;
          phase_next     = PH_LENGTH;
        end else if (pending_cmd == CMD_SPEED) begin
          pending_motor_next = byte_sel;
          phase_next         = PH_SPEED;
        end else begin
          if (byte_sel != SEL_B) begin
            pins_next.a = drive(pins.a, pending_cmd, 8'd0, speed_duty);
          end
          if (byte_sel != SEL_A) begin
            pins_next.b = drive(pins.b, pending_cmd, 8'd0, speed_duty);
          end
          done       = 1'b1;
          phase_next = PH_LENGTH;
        end
      end
      PH_SPEED: begin
        if (pending_motor != SEL_B) begin
          pins_next.a = drive(pins.a, CMD_SPEED, rx_byte, speed_duty);
        end
        if (pending_motor != SEL_A) begin
          pins_next.b = drive(pins.b, CMD_SPEED, rx_byte, speed_duty);
        end
        done       = 1'b1;
        phase_next = PH_LENGTH;
      end
      default: begin
        phase_next = PH_LENGTH;
      end
    endcase
  end

  // Parser and pin registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LENGTH;
      pending_cmd   <= CMD_SPEED;
      pending_motor <= SEL_A;
      pins          <= '0;
    end else if (step) begin
      phase         <= phase_next;
      pending_cmd   <= pending_cmd_next;
      pending_motor <= pending_motor_next;
      pins          <= pins_next;
    end
  end

  assign result = '{pins: pins_next, done: done, bad: bad};

  // A finished frame always hands the parser back to the length byte.
  a_done_to_length: assert property (@(posedge clk) disable iff (rst)
    step && done |=> phase == PH_LENGTH)
    else $error("parser did not return to the length phase after a frame");

  // An unknown command is always reported as a finished frame, and only in the command phase.
  a_bad_is_done: assert property (@(posedge clk) disable iff (rst)
    step && bad |-> done && (phase == PH_COMMAND))
    else $error("bad command flagged outside the command phase");

  // The speed phase is only reached for a speed command.
  a_speed_pending: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SPEED |-> pending_cmd == CMD_SPEED)
    else $error("speed phase with a non-speed command pending");

  // Pins move only when a byte is processed.
  a_pins_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(pins))
    else $error("bridge pins changed without a byte");

endmodule

// File: hdl/hbridge_serial_command_decoder_top.sv
// Path: a received byte passes the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// combinational parser and duty multiply between the two registers.
// Reset: synchronous; the parser waits for a length byte, all pins and duties
// are zero, the standby pin is low and the PWM floor returns to 50.
// ----------------------------------------------------------------------------
// hbridge_serial_command_decoder_top
// Serial command decoder driving two H-bridges and the driver standby pin.
// ----------------------------------------------------------------------------
module hbridge_serial_command_decoder_top (
  input  logic        clk,
  input  logic        rst,
  // Configuration: PWM floor register.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  // Received bytes.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Pin updates, one per received byte.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] a_in1, [1] a_in2, [9:2] a_duty,
                                      // [10] b_in1, [11] b_in2, [19:12] b_duty,
                                      // [20] stby_pin, [23:21] zero
  output logic        m_axis_tlast,   // frame_done
  output logic        m_axis_tuser    // bad_command
);
  import hsd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_res;
  result_t    res;
  logic [7:0] speed_duty;
  logic       out_free;
  logic       step;

  // Pipeline control: the input register drains whenever the result
  // register is empty or being read.
  assign out_free      = !out_valid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  hsd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .speed_byte (in_byte),
    .speed_duty (speed_duty)
  );

  hsd_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (in_byte),
    .speed_duty (speed_duty),
    .result     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  // Output transaction packing.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.pins.stby,
                          out_res.pins.b.duty, out_res.pins.b.in2, out_res.pins.b.in1,
                          out_res.pins.a.duty, out_res.pins.a.in2, out_res.pins.a.in1};
  assign m_axis_tlast  = out_res.done;
  assign m_axis_tuser  = out_res.bad;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the H-bridge serial command decoder. Command frames
// go in as a stream of bytes. Most frames are well formed and carry random
// content, and some stray bytes knock the parser out of step. A scoreboard
// class follows the parser and the pin registers byte by byte and checks every
// pin update against its oldest prediction. The PWM floor is changed between
// phases, while the stream is drained. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import hsd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseBytes = 215;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS   = 2'd0,
    RX_HALF     = 2'd1,
    RX_SPARSE   = 2'd2,
    RX_PERIODIC = 2'd3
  } rx_stall_t;

  // Predicts the registered pins after every received byte and holds the
  // predictions until the matching pin update comes out.
  class motor_pin_predictor;
    logic [7:0] pwm_floor;
    phase_t     phase;
    logic [1:0] pending_cmd;
    sel_t       pending_sel;
    pins_t      pins;
    result_t    expected_pins[$];
    int         errors;

    function new();
      pwm_floor   = PWM_FLOOR_RESET;
      phase       = PH_LENGTH;
      pending_cmd = CMD_SPEED;
      pending_sel = SEL_A;
      pins        = '0;
      errors      = 0;
    endfunction

    // New pin levels of one bridge for a speed, brake or coast command.
    function bridge_t command_bridge(bridge_t br, logic [1:0] cmd, logic [7:0] arg);
      int mag;
      bridge_t r;
      r = br;
      if (cmd == CMD_BRAKE) begin
        r.in1 = 1'b1;
        r.in2 = 1'b1;
      end else if (cmd == CMD_COAST || arg == 8'd0) begin
        r.in1  = 1'b0;
        r.in2  = 1'b0;
        r.duty = DUTY_FULL;
      end else begin
        mag   = arg[7] ? 256 - int'(arg) : int'(arg);
        r.in1 = ~arg[7];
        r.in2 = arg[7];
        if (mag > int'(SPEED_MAX_MAG)) begin
          r.duty = DUTY_FULL;
        end else begin
          r.duty = 8'(int'(pwm_floor) +
                      mag * (int'(DUTY_FULL) - int'(pwm_floor)) / int'(SPEED_MAX_MAG));
        end
      end
      return r;
    endfunction

    function void drive(sel_t sel, logic [1:0] cmd, logic [7:0] arg);
      if (sel != SEL_B) pins.a = command_bridge(pins.a, cmd, arg);
      if (sel != SEL_A) pins.b = command_bridge(pins.b, cmd, arg);
    endfunction

    // Advance the parser by one accepted byte and queue the pin update it causes.
    function void note_rx_byte(logic [7:0] b);
      result_t r;
      sel_t sel;
      r.done = 1'b0;
      r.bad  = 1'b0;
      sel = (b == MOTOR_BYTE_A) ? SEL_A : (b == MOTOR_BYTE_BOTH) ? SEL_BOTH : SEL_B;
      case (phase)
        PH_LENGTH: begin
          phase = PH_COMMAND;
        end
        PH_COMMAND: begin
          if (b > 8'(CMD_STANDBY)) begin
            r.done = 1'b1;
            r.bad  = 1'b1;
            phase  = PH_LENGTH;
          end else begin
            pending_cmd = b[1:0];
            phase       = PH_ARG;
          end
        end
        PH_ARG: begin
          if (pending_cmd == CMD_STANDBY) begin
            pins.stby = (b == 8'd0);
            r.done    = 1'b1;
            phase     = PH_LENGTH;
          end else if (pending_cmd == CMD_SPEED) begin
            pending_sel = sel;
            phase       = PH_SPEED;
          end else begin
            drive(sel, pending_cmd, 8'd0);
            r.done = 1'b1;
            phase  = PH_LENGTH;
          end
        end
        default: begin
          drive(pending_sel, CMD_SPEED, b);
          r.done = 1'b1;
          phase  = PH_LENGTH;
        end
      endcase
      r.pins = pins;
      expected_pins.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    // Check one pin update transaction against the oldest prediction.
    function void check_pin_update(logic [23:0] data, logic last, logic user);
      result_t e;
      if (expected_pins.size() == 0) begin
        errors++;
        $display("%0t: pin update with nothing expected, expected none, actual %h",
                 $time, data);
        return;
      end
      e = expected_pins.pop_front();
      compare("a_in1", 8'(e.pins.a.in1), 8'(data[0]));
      compare("a_in2", 8'(e.pins.a.in2), 8'(data[1]));
      compare("a_duty", e.pins.a.duty, data[9:2]);
      compare("b_in1", 8'(e.pins.b.in1), 8'(data[10]));
      compare("b_in2", 8'(e.pins.b.in2), 8'(data[11]));
      compare("b_duty", e.pins.b.duty, data[19:12]);
      compare("stby_pin", 8'(e.pins.stby), 8'(data[20]));
      compare("frame_done", 8'(e.done), 8'(last));
      compare("bad_command", 8'(e.bad), 8'(user));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  motor_pin_predictor pin_sb = new();
  int        burst_left = 0;
  int        rx_count = 0;
  int        cycle_count = 0;
  int        stall_count = 0;
  rx_stall_t stall_mode = RX_ALWAYS;

  hbridge_serial_command_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure, switching periodically to a randomly picked pattern.
  always @(posedge clk) begin
    stall_count++;
    if (stall_count % 64 == 0) stall_mode <= rx_stall_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_ALWAYS:   m_axis_tready <= 1'b1;
      RX_HALF:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:     m_axis_tready <= stall_count[2];
    endcase
  end

  // Check every pin update transaction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      pin_sb.check_pin_update(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // Send one byte; the sender works in bursts separated by random gaps.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pin_sb.note_rx_byte(b);
    burst_left--;
    rx_count++;
  endtask

  // Drain the stream, then load a new PWM floor.
  task automatic write_floor(input logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pin_sb.expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pin_sb.pwm_floor = value;
    repeat (2) @(posedge clk);
  endtask

  // One random frame: mostly well formed, sometimes a bad command or a stray byte.
  task automatic send_random_frame();
    int pick;
    logic [7:0] cmd_byte;
    logic [7:0] motor_byte;
    logic [7:0] speed_byte;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 40)      cmd_byte = 8'(CMD_SPEED);
    else if (pick < 55) cmd_byte = 8'(CMD_BRAKE);
    else if (pick < 70) cmd_byte = 8'(CMD_COAST);
    else if (pick < 85) cmd_byte = 8'(CMD_STANDBY);
    else                cmd_byte = 8'($urandom_range(4, 255));
    case ($urandom_range(0, 3))
      0:       motor_byte = MOTOR_BYTE_A;
      1:       motor_byte = MOTOR_BYTE_BOTH;
      2:       motor_byte = 8'd1;
      default: motor_byte = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 5))
      0:       speed_byte = 8'd0;
      1:       speed_byte = $urandom_range(0, 1) ? 8'd100 : 8'd156;
      2:       speed_byte = $urandom_range(0, 1) ? 8'd101 : 8'd155;
      3:       speed_byte = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      default: speed_byte = 8'($urandom_range(0, 255));
    endcase
    // Standby frames use the flag position; pick zero often enough.
    if (cmd_byte == 8'(CMD_STANDBY) && $urandom_range(0, 1) == 0) motor_byte = 8'd0;
    send_byte(8'($urandom_range(0, 255)));
    send_byte(cmd_byte);
    if (cmd_byte > 8'(CMD_STANDBY)) return;
    send_byte(motor_byte);
    if (cmd_byte == 8'(CMD_SPEED)) send_byte(speed_byte);
  endtask

  // Main sequence.
  initial begin
    logic [7:0] directed_bytes[$];
    logic [7:0] floors[$];
    int target;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    directed_bytes = '{
      8'h00, 8'(CMD_SPEED), MOTOR_BYTE_A, 8'd100,       // motor A forward at full scale
      8'hFF, 8'(CMD_SPEED), MOTOR_BYTE_BOTH, 8'h80,     // both reverse, most negative
      8'h04, 8'(CMD_SPEED), 8'hFF, 8'h00,               // motor B speed zero coasts
      8'h03, 8'(CMD_BRAKE), MOTOR_BYTE_BOTH,
      8'h03, 8'(CMD_COAST), MOTOR_BYTE_A,
      8'h03, 8'(CMD_STANDBY), 8'h00,
      8'h03, 8'(CMD_STANDBY), 8'hFF,
      8'h02, 8'hFF,                                     // unknown commands
      8'h02, 8'h04
    };
    floors = '{8'd0, 8'd255, 8'd1, 8'd100, 8'($urandom_range(0, 255)), PWM_FLOOR_RESET};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset floor.
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Random phases, one per floor setting.
    foreach (floors[i]) begin
      write_floor(floors[i]);
      target = rx_count + PhaseBytes;
      while (rx_count < target) send_random_frame();
    end
    s_axis_tvalid <= 1'b0;

    while (pin_sb.expected_pins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pin_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
